// ===== sv/arcdir_pkg.sv =====
`default_nettype none

package arcdir_pkg;

  localparam int unsigned EntryBytes = 48;
  localparam int unsigned CountLimit = 200000;

  localparam int unsigned VersionW   = 16;
  localparam int unsigned OffsetW    = 32;
  localparam int unsigned CountW     = 18;
  localparam int unsigned LengthW    = 32;
  localparam int unsigned KeyW       = 16;
  localparam int unsigned PosW       = 6;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 32;

  // Packed result payload: 213 field bits, padded to 27 bytes.
  localparam int unsigned OutDataW   = 216;

  // Version high bytes
  localparam logic [7:0] VerPlain     = 8'h02;
  localparam logic [7:0] VerEncrypted = 8'h03;
  localparam logic [VersionW-1:0] VersionReset = 16'h0300;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegVersion   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDirOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCount     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFileLen   = 3'd3;

  // Entry byte positions
  localparam logic [PosW-1:0] PosOffsetLo = 6'd16;
  localparam logic [PosW-1:0] PosOffsetHi = 6'd19;
  localparam logic [PosW-1:0] PosSizeLo   = 6'd20;
  localparam logic [PosW-1:0] PosSizeHi   = 6'd23;
  localparam logic [PosW-1:0] PosFlags    = 6'd32;
  localparam logic [PosW-1:0] PosTypeLo   = 6'd33;
  localparam logic [PosW-1:0] PosTypeHi   = 6'd35;
  localparam logic [PosW-1:0] PosNameLo   = 6'd36;
  localparam logic [PosW-1:0] PosNameHi   = 6'd43;
  localparam logic [PosW-1:0] PosIdLo     = 6'd44;
  localparam logic [PosW-1:0] PosIdHi     = 6'd46;
  localparam logic [PosW-1:0] PosLast     = 6'(EntryBytes - 1);

  // Status codes
  localparam logic [StatusW-1:0] StatOk         = 3'd0;
  localparam logic [StatusW-1:0] StatBadVersion = 3'd1;
  localparam logic [StatusW-1:0] StatBadCount   = 3'd2;
  localparam logic [StatusW-1:0] StatDirOutside = 3'd3;
  localparam logic [StatusW-1:0] StatResOutside = 3'd4;

  // Start key: low 16 bits of offset * (version low byte + 1)
  function automatic logic [KeyW-1:0] start_key(input logic [VersionW-1:0] ver,
                                                input logic [OffsetW-1:0]  off);
    logic [KeyW+8:0] prod;
    prod = off[KeyW-1:0] * ({1'b0, ver[7:0]} + 9'd1);
    return prod[KeyW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/archive_directory_decoder_core.sv =====
`default_nettype none

// Latency: the result of an entry is valid in the cycle after its 48th byte beat.
// Throughput: one directory byte per cycle; the byte loop is a single registered pass
//   (decrypt, capture shift, position counter), one result beat per 48 byte beats.
// A byte that would close an entry waits only while the previous result is still held.
// Reset (rst_ni low, asynchronous): counters clear, version reads 0x0300, other
//   configuration registers 0, rolling key 0. A write to a mapped index restarts the directory.
module archive_directory_decoder_core
  import arcdir_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,

  // Configuration write channel
  input  wire                 cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire [CfgIdxW-1:0]   cfg_index_i,
  input  wire [CfgDataW-1:0]  cfg_data_i,

  // Byte stream in
  input  wire                 s_axis_tvalid,
  output logic                s_axis_tready,
  input  wire [7:0]           s_axis_tdata,   // [7:0] dir_byte

  // Entry stream out
  output logic                m_axis_tvalid,
  input  wire                 m_axis_tready,
  // [17:0] entry_index, [49:18] resource_offset, [81:50] resource_size,
  // [89:82] entry_flags, [113:90] type_chars, [177:114] name_chars,
  // [209:178] resource_id, [212:210] status, [215:213] zero
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast    // last_entry
);

  // Configuration registers
  logic [VersionW-1:0] version_q, version_d;
  logic [OffsetW-1:0]  dir_off_q, dir_off_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [LengthW-1:0]  arc_len_q, arc_len_d;
  logic                cfg_hit;

  // Directory walk state
  logic [PosW-1:0]     pos_q;
  logic [KeyW-1:0]     key_q;
  logic [CountW-1:0]   done_q;

  // Capture shifters (fully rewritten inside each entry, no reset)
  logic [31:0]         offset_q;
  logic [31:0]         size_q;
  logic [7:0]          flags_q;
  logic [23:0]         type_q;
  logic [63:0]         name_q;
  logic [23:0]         id_q;

  // Result register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;
  logic                out_last_q;

  logic                active;
  logic                closing;
  logic                accept;
  logic                emit;
  logic [7:0]          plain_byte;
  logic [7:0]          ver_hi;
  logic                supported;
  logic [OffsetW:0]    dir_end;
  logic [32:0]         res_end;
  logic [StatusW-1:0]  status;
  logic [23:0]         dir_bytes;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    version_d = version_q;
    dir_off_d = dir_off_q;
    count_d   = count_q;
    arc_len_d = arc_len_q;
    cfg_hit   = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegVersion: begin
          version_d = cfg_data_i[VersionW-1:0];
          cfg_hit   = 1'b1;
        end
        RegDirOffset: begin
          dir_off_d = cfg_data_i[OffsetW-1:0];
          cfg_hit   = 1'b1;
        end
        RegCount: begin
          count_d = cfg_data_i[CountW-1:0];
          cfg_hit = 1'b1;
        end
        RegFileLen: begin
          arc_len_d = cfg_data_i[LengthW-1:0];
          cfg_hit   = 1'b1;
        end
        default: begin
          cfg_hit = 1'b0;   // unmapped index: drop the write
        end
      endcase
    end
  end

  // Bytes past the last entry are taken and dropped.
  assign active  = (done_q < count_q);
  assign closing = active && (pos_q == PosLast);
  // Hold only the closing byte while the previous result still waits.
  assign s_axis_tready = !closing || !out_valid_q || m_axis_tready;
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign emit    = accept && closing;

  assign ver_hi     = version_q[15:8];
  assign supported  = (ver_hi == VerPlain) || (ver_hi == VerEncrypted);
  assign plain_byte = (ver_hi == VerEncrypted) ? (s_axis_tdata ^ key_q[8:1]) : s_axis_tdata;

  // Bounds, computed one bit wider so nothing wraps
  assign dir_bytes = {1'b0, count_q, 5'b0} + {2'b0, count_q, 4'b0};
  assign dir_end   = {1'b0, dir_off_q} + {9'b0, dir_bytes};
  assign res_end   = {1'b0, offset_q} + {1'b0, size_q};

  always_comb begin
    if (!supported) begin
      status = StatBadVersion;
    end else if (count_q > CountW'(CountLimit)) begin
      status = StatBadCount;
    end else if (dir_end > {1'b0, arc_len_q}) begin
      status = StatDirOutside;
    end else if (res_end > {1'b0, arc_len_q}) begin
      status = StatResOutside;
    end else begin
      status = StatOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_q <= VersionReset;
      dir_off_q <= '0;
      count_q   <= '0;
      arc_len_q <= '0;
      pos_q     <= '0;
      key_q     <= start_key(VersionReset, '0);
      done_q    <= '0;
    end else if (cfg_hit) begin
      // Restart the directory from the new register values.
      version_q <= version_d;
      dir_off_q <= dir_off_d;
      count_q   <= count_d;
      arc_len_q <= arc_len_d;
      pos_q     <= '0;
      key_q     <= start_key(version_d, dir_off_d);
      done_q    <= '0;
    end else if (accept && active) begin
      key_q <= key_q + KeyW'(1);
      if (closing) begin
        pos_q  <= '0;
        done_q <= done_q + CountW'(1);
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  // Shift each field in, first byte ending up in the low bits.
  always_ff @(posedge clk_i) begin
    if (accept && active) begin
      if (pos_q >= PosOffsetLo && pos_q <= PosOffsetHi) begin
        offset_q <= {plain_byte, offset_q[31:8]};
      end else if (pos_q >= PosSizeLo && pos_q <= PosSizeHi) begin
        size_q <= {plain_byte, size_q[31:8]};
      end else if (pos_q == PosFlags) begin
        flags_q <= plain_byte;
      end else if (pos_q >= PosTypeLo && pos_q <= PosTypeHi) begin
        type_q <= {plain_byte, type_q[23:8]};
      end else if (pos_q >= PosNameLo && pos_q <= PosNameHi) begin
        name_q <= {plain_byte, name_q[63:8]};
      end else if (pos_q >= PosIdLo && pos_q <= PosIdHi) begin
        id_q <= {plain_byte, id_q[23:8]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= {3'b0, status, plain_byte, id_q, name_q, type_q, flags_q,
                     size_q, offset_q, done_q};
      out_last_q <= ({1'b0, done_q} + 19'd1) == {1'b0, count_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // The entry counter never runs past the configured count.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q <= count_q)
    else $error("entry counter passed entry count");

  // Byte position stays inside one entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pos_q <= PosLast)
    else $error("byte position out of entry");

  // A closing byte loads a new result and returns the byte position to 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (emit && !cfg_hit) |=> (out_valid_q && pos_q == '0))
    else $error("result not loaded after closing byte");

  // A result never gets overwritten while it waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !m_axis_tready) |-> !emit)
    else $error("pending result overwritten");

  // Last flag marks the entry at count minus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_last_q) |->
                   (({1'b0, out_data_q[CountW-1:0]} + 19'd1) == {1'b0, count_q}))
    else $error("last flag on wrong entry");

endmodule

`default_nettype wire

// ===== tb/tb_archive_directory_decoder_core.sv =====
`default_nettype none

module tb_archive_directory_decoder_core;
  import arcdir_pkg::*;

  // How an entry's offset and size words are chosen
  localparam int FitNone   = 0;  // leave them random, usually past the file end
  localparam int FitInside = 1;  // resource lies inside the file
  localparam int FitExact  = 2;  // resource ends exactly at the file end

  typedef struct {
    logic [CountW-1:0]  index;
    logic [31:0]        offset;
    logic [31:0]        size;
    logic [7:0]         flags;
    logic [23:0]        tchars;
    logic [63:0]        name;
    logic [31:0]        id;
    logic [StatusW-1:0] status;
    logic               last;
  } entry_rec_t;

  // Directory predictor plus the queue of entries still owed by the block.
  class dir_scoreboard;
    logic [VersionW-1:0] ver      = VersionReset;
    logic [OffsetW-1:0]  dir_off  = '0;
    logic [CountW-1:0]   count    = '0;
    logic [LengthW-1:0]  arc_len  = '0;

    logic [PosW-1:0]     pos      = '0;
    logic [KeyW-1:0]     key      = '0;
    logic [CountW-1:0]   done     = '0;
    logic [31:0]         off_sh   = '0;
    logic [31:0]         size_sh  = '0;
    logic [7:0]          flags_h  = '0;
    logic [23:0]         tchar_sh = '0;
    logic [63:0]         name_sh  = '0;
    logic [23:0]         id_sh    = '0;

    entry_rec_t due [$];
    int used   = 0;  // bytes that counted toward an entry
    int made   = 0;  // entries predicted
    int errors = 0;
    int shown  = 0;

    function void restart();
      pos      = '0;
      done     = '0;
      // key seed: offset times (version low byte + 1), low 16 bits
      key      = dir_off[KeyW-1:0] + KeyW'(ver[7:0]) * dir_off[KeyW-1:0];
      off_sh   = '0;
      size_sh  = '0;
      flags_h  = '0;
      tchar_sh = '0;
      name_sh  = '0;
      id_sh    = '0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        RegVersion:   ver      = data[VersionW-1:0];
        RegDirOffset: dir_off  = data[OffsetW-1:0];
        RegCount:     count    = data[CountW-1:0];
        RegFileLen:   arc_len  = data[LengthW-1:0];
        default:      return;
      endcase
      restart();
    endfunction

    // Note one accepted directory byte; queue an entry when byte 47 lands.
    function void take_byte(logic [7:0] raw);
      logic [7:0]         b;
      logic [7:0]         hi;
      logic [33:0]        dir_end;
      logic [32:0]        res_end;
      entry_rec_t         e;
      if (done >= count) return;
      used++;
      hi = ver[15:8];
      b  = raw;
      if (hi == VerEncrypted) b = raw ^ key[8:1];
      key = key + 1'b1;

      if (pos >= PosOffsetLo && pos <= PosOffsetHi) off_sh = {b, off_sh[31:8]};
      else if (pos >= PosSizeLo && pos <= PosSizeHi) size_sh = {b, size_sh[31:8]};
      else if (pos == PosFlags) flags_h = b;
      else if (pos >= PosTypeLo && pos <= PosTypeHi) tchar_sh = {b, tchar_sh[23:8]};
      else if (pos >= PosNameLo && pos <= PosNameHi) name_sh = {b, name_sh[63:8]};
      else if (pos >= PosIdLo && pos <= PosIdHi) id_sh = {b, id_sh[23:8]};

      if (pos != PosLast) begin
        pos = pos + 1'b1;
        return;
      end

      // bounds are taken without wrap-around
      dir_end = 34'(dir_off) + 34'(count) * 34'(EntryBytes);
      res_end = 33'(off_sh) + 33'(size_sh);
      if (hi != VerPlain && hi != VerEncrypted) e.status = StatBadVersion;
      else if (32'(count) > CountLimit)        e.status = StatBadCount;
      else if (dir_end > 34'(arc_len))         e.status = StatDirOutside;
      else if (res_end > 33'(arc_len))         e.status = StatResOutside;
      else                                     e.status = StatOk;

      e.index  = done;
      e.offset = off_sh;
      e.size   = size_sh;
      e.flags  = flags_h;
      e.tchars = tchar_sh;
      e.name   = name_sh;
      e.id     = {b, id_sh};
      e.last   = (32'(done) + 1 == 32'(count));
      due.push_back(e);
      made++;

      pos  = '0;
      done = done + 1'b1;
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
      end
    endfunction

    function void check_entry(entry_rec_t got);
      entry_rec_t want;
      if (due.size() == 0) begin
        flag("entry beat with nothing owed, entry_index", 0, got.index);
        return;
      end
      want = due.pop_front();
      if (got.index  !== want.index)  flag("entry_index", want.index, got.index);
      if (got.offset !== want.offset) flag("resource_offset", want.offset, got.offset);
      if (got.size   !== want.size)   flag("resource_size", want.size, got.size);
      if (got.flags  !== want.flags)  flag("entry_flags", want.flags, got.flags);
      if (got.tchars !== want.tchars) flag("type_chars", want.tchars, got.tchars);
      if (got.name   !== want.name)   flag("name_chars", want.name, got.name);
      if (got.id     !== want.id)     flag("resource_id", want.id, got.id);
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.last   !== want.last)   flag("last_entry", want.last, got.last);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  // Clock, reset and block inputs, all known from time zero
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_valid_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i   = RegVersion;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic [7:0]          s_axis_tdata  = '0;
  logic                m_axis_tready = 1'b0;

  logic                cfg_ready_o;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  dir_scoreboard board;
  entry_rec_t    seen_entry;

  int gap_pct = 10;  // chance in percent of a sender gap after a byte beat
  bit calm    = 1'b0;  // set for the closing stretch: no gaps, no stalls
  int rx_left = 0;

  archive_directory_decoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Receiver: alternate ready stretches with stall bursts.
  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        rx_left = $urandom_range(1, 13);
      end else begin
        m_axis_tready <= 1'b1;
        rx_left = $urandom_range(1, 40);
      end
    end else begin
      rx_left--;
    end
  end

  // Entry monitor: unpack each accepted result beat and score it.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_entry.index  = m_axis_tdata[17:0];
      seen_entry.offset = m_axis_tdata[49:18];
      seen_entry.size   = m_axis_tdata[81:50];
      seen_entry.flags  = m_axis_tdata[89:82];
      seen_entry.tchars = m_axis_tdata[113:90];
      seen_entry.name   = m_axis_tdata[177:114];
      seen_entry.id     = m_axis_tdata[209:178];
      seen_entry.status = m_axis_tdata[212:210];
      seen_entry.last   = m_axis_tlast;
      board.check_entry(seen_entry);
    end
  end

  // Hold one config beat until taken; the caller lowers valid afterwards.
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  // Write the registers selected by mask, in index order, back to back.
  task automatic program_regs(input logic [15:0] v, input logic [31:0] o,
                              input logic [17:0] c, input logic [31:0] l,
                              input logic [3:0] mask);
    if (mask[0]) put_reg(RegVersion, {16'h0, v});
    if (mask[1]) put_reg(RegDirOffset, o);
    if (mask[2]) put_reg(RegCount, {14'h0, c});
    if (mask[3]) put_reg(RegFileLen, l);
    cfg_valid_i <= 1'b0;
  endtask

  // Present one directory byte, wait for its beat, then maybe go quiet a while.
  task automatic send_byte(input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.take_byte(b);
    if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic send_junk(input int n);
    for (int i = 0; i < n; i++) send_byte(8'($urandom));
  endtask

  // Build one 48-byte entry in plain text, then scramble it with the live key
  // when the directory is encrypted. fill < 0 means random content.
  task automatic send_entry(input int fit, input int fill);
    logic [7:0]  plain [EntryBytes];
    logic [31:0] lim;
    logic [31:0] ro;
    logic [31:0] rs;
    logic [7:0]  raw;
    lim = board.arc_len;
    ro  = $urandom_range(0, lim);
    rs  = (fit == FitExact) ? lim - ro : $urandom_range(0, lim - ro);
    for (int i = 0; i < EntryBytes; i++) plain[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    if (fit != FitNone) begin
      for (int i = 0; i < 4; i++) begin
        plain[PosOffsetLo + i] = ro[8*i +: 8];
        plain[PosSizeLo + i]   = rs[8*i +: 8];
      end
    end
    for (int i = 0; i < EntryBytes; i++) begin
      raw = plain[i];
      if (board.ver[15:8] == VerEncrypted && board.done < board.count) raw ^= board.key[8:1];
      send_byte(raw);
    end
  endtask

  // Drop valid and hold off until every owed entry has been seen.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // Drain, then let the clock run on for ignored bytes still in flight.
  task automatic settle();
    drain();
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    #10_000_000;
    $display("archive_directory_decoder_core: mismatch");
    $finish;
  end

  initial begin
    logic [15:0] v;
    logic [31:0] o;
    logic [31:0] l;
    logic [17:0] c;
    logic [33:0] dend;
    logic [3:0]  mask;
    int          n;
    int          r;
    int          first_made;

    board = new;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset entry_count is 0: these bytes must vanish.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h5A);
    settle();

    // Plain directory, all-ones entry then all-zeros entry; drain between them.
    program_regs({VerPlain, 8'h00}, 32'h0, 18'd2, 32'hFFFF_FFFF, 4'hF);
    send_entry(FitNone, 8'hFF);
    drain();
    send_entry(FitNone, 8'h00);
    send_junk(4);
    settle();

    // Encrypted with the largest key multiplier; directory runs past the file end.
    program_regs({VerEncrypted, 8'hFF}, 32'hFFFF_FFFF, 18'd1, 32'hFFFF_FFFF, 4'hF);
    send_entry(FitInside, -1);
    send_junk(3);
    settle();

    // Unsupported version words at both extremes.
    program_regs(16'h0000, 32'h0, 18'd1, 32'd48, 4'hF);
    send_entry(FitInside, -1);
    settle();
    program_regs(16'hFFFF, 32'h0, 18'd1, 32'd48, 4'b0001);
    send_entry(FitInside, -1);
    settle();

    // Count at the top of its field, then exactly at the plausibility limit.
    program_regs(VersionReset, 32'h1234_5678, 18'h3FFFF, 32'hFFFF_FFFF, 4'hF);
    send_entry(FitInside, -1);
    settle();
    program_regs(VersionReset, 32'h0, 18'(CountLimit), 32'hFFFF_FFFF, 4'b0101);
    send_entry(FitExact, -1);
    settle();

    // Directory and resource both end exactly at the file end; then one byte short.
    program_regs({VerEncrypted, 8'h07}, 32'd100, 18'd1, 32'd148, 4'hF);
    send_entry(FitExact, -1);
    settle();
    program_regs(16'h0, 32'h0, 18'h0, 32'd147, 4'b1000);
    send_entry(FitInside, -1);
    settle();

    // Abandon an entry partway: the next write restarts the directory.
    program_regs({VerEncrypted, 8'h80}, 32'h0000_ABCD, 18'd3, 32'hFFFF_FFFF, 4'hF);
    send_junk(20);
    settle();
    program_regs(16'h0, 32'h0, 18'd2, 32'h0, 4'b0100);
    send_entry(FitInside, -1);
    send_entry(FitInside, -1);
    send_junk(5);
    settle();

    // Random phases: mostly well-formed directories, some noise and cut-offs.
    first_made = board.made;
    while (board.used < 1650 || board.made < first_made + 16) begin
      calm = (board.made >= first_made + 12) && (board.used >= 1400);

      r = $urandom_range(0, 9);
      if (r < 5)       v = {VerEncrypted, 8'($urandom)};
      else if (r < 8)  v = {VerPlain, 8'($urandom)};
      else if (r == 8) v = 16'($urandom);
      else             v = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;

      r = $urandom_range(0, 3);
      if (r == 0)      o = 32'($urandom_range(0, 4096));
      else if (r == 1) o = 32'hFFFF_FFFF - 32'($urandom_range(0, 4096));
      else             o = $urandom;

      r = $urandom_range(0, 11);
      if (r < 8)       c = 18'($urandom_range(1, 4));
      else if (r == 8) c = '0;
      else if (r == 9) c = 18'($urandom_range(5, 9));
      else if (r == 10) c = 18'($urandom_range(CountLimit - 1, CountLimit + 1));
      else             c = 18'($urandom_range(CountLimit + 2, 262143));

      // pick a file length that mostly holds the directory, sometimes exactly
      dend = 34'(o) + 34'(c) * 34'(EntryBytes);
      r = $urandom_range(0, 9);
      if (r < 5 && dend <= 34'hFFFF_FFFF)
        l = dend[31:0] + $urandom_range(0, 32'hFFFF_FFFF - dend[31:0]);
      else if (r == 5 && dend <= 34'hFFFF_FFFF)
        l = dend[31:0];
      else if (r < 8)
        l = 32'hFFFF_FFFF;
      else
        l = $urandom;

      mask = ($urandom_range(0, 3) != 0) ? 4'hF : 4'(1 << $urandom_range(0, 3));
      program_regs(v, o, c, l, mask);
      gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 25);

      n = $urandom_range(1, 4);
      if (n > board.count) n = board.count;
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(0, 19);
        send_entry((r < 14) ? FitInside : (r < 15) ? FitExact : FitNone, -1);
        if (!calm && $urandom_range(0, 7) == 0) drain();
      end

      // trailing bytes: a cut-off entry or bytes past the last entry
      r = $urandom_range(0, 3);
      if (r == 0)      send_junk($urandom_range(1, 47));
      else if (r == 1) send_junk($urandom_range(1, 6));
      settle();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("archive_directory_decoder_core: match");
    end else begin
      $display("archive_directory_decoder_core: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
